// File: hdl/led_display_key_matrix_scanner_defines.svh
// Assertion macros for the LED display and key matrix scanner.
`ifndef LED_DISPLAY_KEY_MATRIX_SCANNER_DEFINES_SVH
`define LED_DISPLAY_KEY_MATRIX_SCANNER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define LDKS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scanner assertion failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define LDKS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scanner assertion failed");
`else
`define LDKS_ASSERT_NOW(label, ante, cons)
`define LDKS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: hdl/ldks_pkg.sv
// Constants, slot codes and the bit remap function of the LED display and key scanner.
package ldks_pkg;

	// Slot codes; display slots come first, then the key columns.
	localparam logic [3:0] SLOT_LED_A      = 4'd0;
	localparam logic [3:0] SLOT_LED_B      = 4'd1;
	localparam logic [3:0] SLOT_DIGIT_L    = 4'd2;
	localparam logic [3:0] SLOT_DIGIT_M    = 4'd3;
	localparam logic [3:0] SLOT_DIGIT_R    = 4'd4;
	localparam logic [3:0] SLOT_KEY_CLEAR  = 4'd5;
	localparam logic [3:0] SLOT_KEY_COL0   = 4'd6;
	localparam logic [3:0] SLOT_KEY_COL1   = 4'd7;
	localparam logic [3:0] SLOT_KEY_COL2   = 4'd8;
	localparam logic [3:0] SLOT_KEY_COL3   = 4'd9;
	localparam logic [3:0] SLOT_KEY_LAST   = 4'd10;

	localparam int KEY_COLS = 5;

	// One-hot select bytes of the display slots, and an empty select for the key slots.
	localparam logic [7:0] SEL_LED_A   = 8'h04;
	localparam logic [7:0] SEL_LED_B   = 8'h02;
	localparam logic [7:0] SEL_DIGIT_L = 8'h80;
	localparam logic [7:0] SEL_DIGIT_M = 8'h20;
	localparam logic [7:0] SEL_DIGIT_R = 8'h40;
	localparam logic [7:0] SEL_NONE    = 8'h00;

	// Column drive bytes, one column pulled low per key slot.
	localparam logic [7:0] COL_BYTE_0 = ~8'h20;
	localparam logic [7:0] COL_BYTE_1 = ~8'h08;
	localparam logic [7:0] COL_BYTE_2 = ~8'h04;
	localparam logic [7:0] COL_BYTE_3 = ~8'h02;
	localparam logic [7:0] COL_BYTE_4 = ~8'h40;
	localparam logic [7:0] COL_BYTE_5 = ~8'h01;

	typedef logic [7:0] dest_map_t [8];

	// Destination bit of each source bit; the LED A group has only seven bits.
	localparam dest_map_t LED_A_DEST = '{8'h80, 8'h40, 8'h20, 8'h08,
		8'h10, 8'h02, 8'h01, 8'h00};
	localparam dest_map_t LED_B_DEST = '{8'h80, 8'h40, 8'h20, 8'h08,
		8'h10, 8'h02, 8'h01, 8'h04};
	localparam dest_map_t SEG_DEST   = '{8'h40, 8'h10, 8'h04, 8'h02,
		8'h08, 8'h20, 8'h80, 8'h01};

	// Moves each set source bit to the place its map gives.
	function automatic logic [7:0] remap(input logic [7:0] src, input dest_map_t dest);
		logic [7:0] v;
		v = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (src[i]) begin
				v = v | dest[i];
			end
		end
		return v;
	endfunction

	// Stream payloads.
	typedef struct packed {
		logic [5:0]  pad;
		logic [7:0]  digit_right;
		logic [7:0]  digit_middle;
		logic [7:0]  digit_left;
		logic [14:0] led_bits;
		logic [2:0]  key_lines;
	} in_item_t;

	typedef struct packed {
		logic        button_pressed;
		logic [14:0] key_map;
		logic [15:0] frame_word;
	} out_item_t;

endpackage

// File: hdl/led_display_key_matrix_scanner.sv
// Top level of the multiplexed LED display and key matrix scanner.
//
// Each accepted input transaction is one scan slot and yields exactly one output
// transaction. Eleven slots form a scan: LED group A, LED group B, the left,
// middle and right digits, then six key columns. The output word carries a
// one-hot select in the high byte (all zeros in key slots) and the segment
// or column byte in the low byte. Key lines gathered over the columns are
// published with the next LED group A slot, whose own result already shows
// them. A transaction passes through an input register, then the result
// register; the slot counter and key accumulator update between the two. A
// new slot is accepted in every cycle unless the input side stalls, which it
// does only when the result register is full and not being taken.
`include "led_display_key_matrix_scanner_defines.svh"

module led_display_key_matrix_scanner import ldks_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// s_tdata: key_lines[2:0], led_bits[17:3], digit_left[25:18],
	// digit_middle[33:26], digit_right[41:34], zeros[47:42]
	input  logic [47:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata: frame_word[15:0], key_map[30:16], button_pressed[31]
	output logic [31:0] m_tdata
);

	in_item_t    item_s1;
	logic        valid_s1;
	out_item_t   result_q;
	logic        result_valid_q;

	logic [3:0]  slot_q;
	logic [14:0] key_acc_q;
	logic        button_acc_q;
	logic [14:0] pub_keys_q;
	logic        pub_button_q;

	logic        advance;
	logic [15:0] frame_word;
	logic [14:0] key_acc_next;
	logic        button_acc_next;
	logic [14:0] pub_keys_next;
	logic        pub_button_next;
	logic [3:0]  slot_next;
	logic [14:0] key_set;

	// The slot in the input register moves on whenever the result register frees up.
	assign advance  = valid_s1 && (!result_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= in_item_t'(s_tdata);
		end
	end

	// Keys pressed in the current column: each low line sets its bit.
	always_comb begin
		key_set = '0;
		for (int j = 0; j < KEY_COLS; j++) begin
			if (slot_q == SLOT_KEY_COL0 + 4'(j)) begin
				key_set[j]              = !item_s1.key_lines[0];
				key_set[j + KEY_COLS]   = !item_s1.key_lines[1];
				key_set[j + 2*KEY_COLS] = !item_s1.key_lines[2];
			end
		end
	end

	// Frame word and state update for the slot in the input register.
	always_comb begin
		key_acc_next    = key_acc_q;
		button_acc_next = button_acc_q;
		pub_keys_next   = pub_keys_q;
		pub_button_next = pub_button_q;
		frame_word      = 16'h0000;
		case (slot_q)
			SLOT_LED_A: begin
				button_acc_next = button_acc_q || !item_s1.key_lines[1];
				pub_keys_next   = key_acc_q;
				pub_button_next = button_acc_next;
				frame_word      = {SEL_LED_A,
					remap({1'b0, item_s1.led_bits[14:8]}, LED_A_DEST)};
			end
			SLOT_LED_B: begin
				frame_word = {SEL_LED_B, remap(item_s1.led_bits[7:0], LED_B_DEST)};
			end
			SLOT_DIGIT_L: begin
				frame_word = {SEL_DIGIT_L, remap(item_s1.digit_left, SEG_DEST)};
			end
			SLOT_DIGIT_M: begin
				frame_word = {SEL_DIGIT_M, remap(item_s1.digit_middle, SEG_DEST)};
			end
			SLOT_DIGIT_R: begin
				frame_word = {SEL_DIGIT_R, remap(item_s1.digit_right, SEG_DEST)};
			end
			SLOT_KEY_CLEAR: begin
				key_acc_next    = '0;
				button_acc_next = 1'b0;
				frame_word      = {SEL_NONE, COL_BYTE_0};
			end
			SLOT_KEY_COL0: begin
				key_acc_next = key_acc_q | key_set;
				frame_word   = {SEL_NONE, COL_BYTE_1};
			end
			SLOT_KEY_COL1: begin
				key_acc_next = key_acc_q | key_set;
				frame_word   = {SEL_NONE, COL_BYTE_2};
			end
			SLOT_KEY_COL2: begin
				key_acc_next = key_acc_q | key_set;
				frame_word   = {SEL_NONE, COL_BYTE_3};
			end
			SLOT_KEY_COL3: begin
				key_acc_next = key_acc_q | key_set;
				frame_word   = {SEL_NONE, COL_BYTE_4};
			end
			SLOT_KEY_LAST: begin
				key_acc_next = key_acc_q | key_set;
				frame_word   = {SEL_NONE, COL_BYTE_5};
			end
			default: begin
				frame_word = 16'h0000;
			end
		endcase
		slot_next = (slot_q >= SLOT_KEY_LAST) ? SLOT_LED_A : slot_q + 4'd1;
	end

	// Scan state, updated once per slot that moves to the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q       <= SLOT_LED_A;
			key_acc_q    <= '0;
			button_acc_q <= 1'b0;
			pub_keys_q   <= '0;
			pub_button_q <= 1'b0;
		end else if (advance) begin
			slot_q       <= slot_next;
			key_acc_q    <= key_acc_next;
			button_acc_q <= button_acc_next;
			pub_keys_q   <= pub_keys_next;
			pub_button_q <= pub_button_next;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (m_tready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.frame_word     <= frame_word;
			result_q.key_map        <= pub_keys_next;
			result_q.button_pressed <= pub_button_next;
		end
	end

	assign m_tvalid = result_valid_q;
	assign m_tdata  = result_q;

	// The slot counter never leaves the scan.
	`LDKS_ASSERT_NOW(a_slot_in_scan, 1'b1, slot_q <= SLOT_KEY_LAST)
	// Scan state moves only with a slot.
	`LDKS_ASSERT_NEXT(a_state_holds, !advance, $stable(slot_q) && $stable(key_acc_q))
	// The clear column empties the key accumulator.
	`LDKS_ASSERT_NEXT(a_clear_column, advance && slot_q == SLOT_KEY_CLEAR, key_acc_q == '0)
	// The LED group A slot publishes the finished key map in its own result.
	`LDKS_ASSERT_NEXT(a_publish, advance && slot_q == SLOT_LED_A,
		m_tvalid && m_tdata[30:16] == $past(key_acc_q))

endmodule
